[hdl/spadd_pkg.sv]
// shared types and constants of the sparse polynomial adder
`timescale 1ns / 1ps
`default_nettype none
package spadd_pkg;

  localparam int unsigned MAX_TERMS = 32;
  localparam int unsigned IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned EXP_W     = 16;
  localparam int unsigned SUM_W     = COEFF_W + 1;
  localparam int unsigned WORD_W    = COEFF_W + EXP_W;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_MERGE  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  // one read port and one write port of a term store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage
`default_nettype wire

[hdl/spadd_if.sv]
// request channels of the sparse polynomial adder
`timescale 1ns / 1ps
`default_nettype none
interface spadd_in_if import spadd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic signed [COEFF_W-1:0] coeff_in;
  logic [EXP_W-1:0]          exp_in;

  modport source (output valid, op, coeff_in, exp_in, input ready);
  modport sink (input valid, op, coeff_in, exp_in, output ready);
endinterface

interface spadd_out_if import spadd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] coeff_out;
  logic [EXP_W-1:0]        exp_out;
  logic                    last;
  logic                    empty_res;

  modport source (output valid, coeff_out, exp_out, last, empty_res, input ready);
  modport sink (input valid, coeff_out, exp_out, last, empty_res, output ready);
endinterface
`default_nettype wire

[hdl/sparse_polynomial_add_merge_top.sv]
// top level of the sparse polynomial adder
`timescale 1ns / 1ps
`default_nettype none
// Sparse polynomial adder. Load requests (op 0 for list A, op 1 for list B) each store one
// term; terms beyond MAX_TERMS per list are dropped. A merge request (op 2) walks both lists
// in load order, emitting the larger exponent first and a summed coefficient on equal
// exponents (zero sums included), then the leftovers; the final result has last set, and an
// empty merge gives one result with empty_res set. Both lists are cleared afterwards. The
// merge delivers one result per cycle while the sink is ready and holds off new requests
// until its final result is registered; this rate is set by the registered read of the two
// term memories, whose next address depends on the current exponent compare. Op code 3 is
// accepted and ignored.
module sparse_polynomial_add_merge_top import spadd_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  spadd_in_if.sink    in_i,
  spadd_out_if.source out_o
);

  ram_req_t          req_a, req_b;
  logic [WORD_W-1:0] rd_a, rd_b;

  spadd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .req_a_o (req_a),
    .req_b_o (req_b),
    .rd_a_i  (rd_a),
    .rd_b_i  (rd_b)
  );

  spadd_ram #(.DEPTH(MAX_TERMS), .WIDTH(WORD_W), .ADDR_W(IDX_W)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (req_a.we),
    .waddr_i (req_a.waddr),
    .wdata_i (req_a.wdata),
    .raddr_i (req_a.raddr),
    .rdata_o (rd_a)
  );

  spadd_ram #(.DEPTH(MAX_TERMS), .WIDTH(WORD_W), .ADDR_W(IDX_W)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (req_b.we),
    .waddr_i (req_b.waddr),
    .wdata_i (req_b.wdata),
    .raddr_i (req_b.raddr),
    .rdata_o (rd_b)
  );

endmodule
`default_nettype wire

[hdl/spadd_ram.sv]
// simple dual-port memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module spadd_ram #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/spadd_ctrl.sv]
// load counters, merge sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
module spadd_ctrl import spadd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  spadd_in_if.sink         in_i,
  spadd_out_if.source      out_o,
  output ram_req_t         req_a_o,
  output ram_req_t         req_b_o,
  input  wire logic [WORD_W-1:0] rd_a_i,
  input  wire logic [WORD_W-1:0] rd_b_i
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_a_q, count_a_d, count_b_q, count_b_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_coeff_q, out_coeff_d;
  logic [EXP_W-1:0]        out_exp_q, out_exp_d;
  logic                    out_last_q, out_last_d;
  logic                    out_empty_q, out_empty_d;

  logic in_fire, out_fire, step;
  logic load_a, load_b, merge_req;
  logic a_av, b_av, take_a, take_b, last_term;
  logic [COEFF_W-1:0] ca, cb;
  logic [EXP_W-1:0]   ea, eb;
  logic signed [SUM_W-1:0] add_a, add_b;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;
  assign step       = (state_q == ST_MERGE) && (!out_valid_q || out_o.ready);

  assign load_a    = in_fire && (in_i.op == OP_LOAD_A) && (count_a_q < CNT_W'(MAX_TERMS));
  assign load_b    = in_fire && (in_i.op == OP_LOAD_B) && (count_b_q < CNT_W'(MAX_TERMS));
  assign merge_req = in_fire && (in_i.op == OP_MERGE);

  assign ca = rd_a_i[WORD_W-1:EXP_W];
  assign ea = rd_a_i[EXP_W-1:0];
  assign cb = rd_b_i[WORD_W-1:EXP_W];
  assign eb = rd_b_i[EXP_W-1:0];

  // larger exponent first, both on a tie
  assign a_av   = i_q < count_a_q;
  assign b_av   = j_q < count_b_q;
  assign take_a = a_av && (!b_av || (ea >= eb));
  assign take_b = b_av && (!a_av || (eb >= ea));
  assign add_a  = take_a ? SUM_W'(signed'(ca)) : '0;
  assign add_b  = take_b ? SUM_W'(signed'(cb)) : '0;

  always_comb begin
    state_d     = state_q;
    count_a_d   = count_a_q + CNT_W'(load_a);
    count_b_d   = count_b_q + CNT_W'(load_b);
    i_d         = '0;
    j_d         = '0;
    last_term   = 1'b0;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    out_coeff_d = out_coeff_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    unique case (state_q)
      ST_IDLE: begin
        if (merge_req) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        i_d       = i_q;
        j_d       = j_q;
        if (step) begin
          i_d         = i_q + CNT_W'(take_a);
          j_d         = j_q + CNT_W'(take_b);
          last_term   = (i_d >= count_a_q) && (j_d >= count_b_q);
          out_valid_d = 1'b1;
          out_coeff_d = add_a + add_b;
          out_exp_d   = take_a ? ea : (take_b ? eb : '0);
          out_last_d  = last_term;
          out_empty_d = !a_av && !b_av;
          if (last_term) begin
            state_d   = ST_IDLE;
            count_a_d = '0;
            count_b_d = '0;
            i_d       = '0;
            j_d       = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_a_q   <= '0;
      count_b_q   <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_a_q   <= count_a_d;
      count_b_q   <= count_b_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_coeff_q <= out_coeff_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  // read addresses follow the next walk position, so the registered read data lines up with i_q and j_q
  always_comb begin
    req_a_o.we    = load_a;
    req_a_o.waddr = count_a_q[IDX_W-1:0];
    req_a_o.wdata = {in_i.coeff_in, in_i.exp_in};
    req_a_o.raddr = i_d[IDX_W-1:0];
    req_b_o.we    = load_b;
    req_b_o.waddr = count_b_q[IDX_W-1:0];
    req_b_o.wdata = {in_i.coeff_in, in_i.exp_in};
    req_b_o.raddr = j_d[IDX_W-1:0];
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.coeff_out = out_coeff_q;
  assign out_o.exp_out   = out_exp_q;
  assign out_o.last      = out_last_q;
  assign out_o.empty_res = out_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_a_q <= CNT_W'(MAX_TERMS)) && (count_b_q <= CNT_W'(MAX_TERMS)))
    else $error("term count above capacity");

  a_last_ends_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_term) |=> (state_q == ST_IDLE) && (count_a_q == '0) && (count_b_q == '0))
    else $error("merge did not finish after last term");

  a_no_accept_in_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> !in_i.ready)
    else $error("request accepted during merge");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> out_last_q)
    else $error("empty result not flagged last");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (i_q <= count_a_q) && (j_q <= count_b_q))
    else $error("merge walked past a list end");

endmodule
`default_nettype wire

[tb/sparse_polynomial_add_merge_top_tb.sv]
// testbench of the sparse polynomial adder: random loads and merges checked against a predictor
`timescale 1ns / 1ps
module sparse_polynomial_add_merge_top_tb;
  import spadd_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned RAND_ITEMS  = 230;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_TERMS + 8;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [COEFF_W-1:0] coeff;
    logic [EXP_W-1:0]          exponent;
  } term_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] coeff;
    logic [EXP_W-1:0]        exponent;
    logic                    last;
    logic                    empty_res;
  } sum_term_t;

  logic clk_i;
  logic rst_ni;

  spadd_in_if  in_bus ();
  spadd_out_if out_bus ();

  sparse_polynomial_add_merge_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  term_req_t   req_queue[$];
  sum_term_t   expected_terms[$];

  // predictor copy of the two term lists
  logic signed [COEFF_W-1:0] list_a_coeff[MAX_TERMS];
  logic [EXP_W-1:0]          list_a_exp[MAX_TERMS];
  logic signed [COEFF_W-1:0] list_b_coeff[MAX_TERMS];
  logic [EXP_W-1:0]          list_b_exp[MAX_TERMS];
  int unsigned               held_a = 0;
  int unsigned               held_b = 0;

  int unsigned sent_count     = 0;
  int unsigned total_count    = 0;
  int unsigned counted_items  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // idle pattern: sender 33 / receiver 49, then swapped, then no idling
  function automatic int unsigned idle_phase();
    if (total_count == 0) return 2;
    return (sent_count * 3) / total_count;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (idle_phase())
      0: return 33;
      1: return 49;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct();
    case (idle_phase())
      0: return 49;
      1: return 33;
      default: return 0;
    endcase
  endfunction

  task automatic predict_sum_terms(input term_req_t req);
    int unsigned i;
    int unsigned j;
    sum_term_t   t;
    case (req.op)
      OP_LOAD_A: begin
        if (held_a < MAX_TERMS) begin
          list_a_coeff[held_a] = req.coeff;
          list_a_exp[held_a]   = req.exponent;
          held_a++;
        end
      end
      OP_LOAD_B: begin
        if (held_b < MAX_TERMS) begin
          list_b_coeff[held_b] = req.coeff;
          list_b_exp[held_b]   = req.exponent;
          held_b++;
        end
      end
      OP_MERGE: begin
        if (held_a == 0 && held_b == 0) begin
          t = '{coeff: '0, exponent: '0, last: 1'b1, empty_res: 1'b1};
          expected_terms.push_back(t);
        end else begin
          i = 0;
          j = 0;
          t = '0;
          while (i < held_a && j < held_b) begin
            if (list_a_exp[i] > list_b_exp[j]) begin
              t.coeff    = {list_a_coeff[i][COEFF_W-1], list_a_coeff[i]};
              t.exponent = list_a_exp[i];
              i++;
            end else if (list_a_exp[i] < list_b_exp[j]) begin
              t.coeff    = {list_b_coeff[j][COEFF_W-1], list_b_coeff[j]};
              t.exponent = list_b_exp[j];
              j++;
            end else begin
              // equal exponents: one summed term, zero sums included
              t.coeff    = {list_a_coeff[i][COEFF_W-1], list_a_coeff[i]} +
                           {list_b_coeff[j][COEFF_W-1], list_b_coeff[j]};
              t.exponent = list_a_exp[i];
              i++;
              j++;
            end
            expected_terms.push_back(t);
          end
          for (; i < held_a; i++) begin
            t.coeff    = {list_a_coeff[i][COEFF_W-1], list_a_coeff[i]};
            t.exponent = list_a_exp[i];
            expected_terms.push_back(t);
          end
          for (; j < held_b; j++) begin
            t.coeff    = {list_b_coeff[j][COEFF_W-1], list_b_coeff[j]};
            t.exponent = list_b_exp[j];
            expected_terms.push_back(t);
          end
          t = expected_terms.pop_back();
          t.last = 1'b1;
          expected_terms.push_back(t);
          held_a = 0;
          held_b = 0;
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    term_req_t next_req;
    if (!rst_ni) begin
      in_bus.valid    <= 1'b0;
      in_bus.op       <= OP_LOAD_A;
      in_bus.coeff_in <= '0;
      in_bus.exp_in   <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        next_req.op       = in_bus.op;
        next_req.coeff    = in_bus.coeff_in;
        next_req.exponent = in_bus.exp_in;
        predict_sum_terms(next_req);
        sent_count++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_req = req_queue.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.op       <= next_req.op;
          in_bus.coeff_in <= next_req.coeff;
          in_bus.exp_in   <= next_req.exponent;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    sum_term_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_terms.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result coeff=%0d exp=%0d last=%0b empty=%0b",
                     out_bus.coeff_out, out_bus.exp_out, out_bus.last, out_bus.empty_res);
          mismatch_count++;
        end else begin
          want = expected_terms.pop_front();
          if (out_bus.coeff_out !== want.coeff || out_bus.exp_out !== want.exponent ||
              out_bus.last !== want.last || out_bus.empty_res !== want.empty_res) begin
            if (mismatch_count < 10)
              $display("mismatch: want c/e/l/z %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                       want.coeff, want.exponent, want.last, want.empty_res,
                       out_bus.coeff_out, out_bus.exp_out, out_bus.last, out_bus.empty_res);
            mismatch_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  task automatic queue_request(input logic [1:0] op, input logic [15:0] coeff,
                               input logic [15:0] exponent);
    term_req_t r;
    r.op       = op;
    r.coeff    = coeff;
    r.exponent = exponent;
    req_queue.push_back(r);
    counted_items++;
  endtask

  // one pair of term lists, loads interleaved, optional noise, optional merge
  task automatic queue_polynomials(input int unsigned na, input int unsigned nb,
                                   input bit ordered, input bit do_merge);
    logic [15:0] exps_a[$];
    logic [15:0] exps_b[$];
    logic [15:0] coeffs_a[$];
    logic [15:0] coeffs_b[$];
    int unsigned ia;
    int unsigned ib;
    for (int k = 0; k < na; k++) exps_a.push_back(16'($urandom));
    for (int k = 0; k < nb; k++) begin
      if (na != 0 && $urandom_range(1) == 0)
        exps_b.push_back(exps_a[$urandom_range(na - 1)]);
      else
        exps_b.push_back(16'($urandom));
    end
    if (ordered) begin
      exps_a.rsort();
      exps_b.rsort();
    end
    for (int k = 0; k < na; k++) coeffs_a.push_back(16'($urandom));
    for (int k = 0; k < nb; k++) begin
      coeffs_b.push_back(16'($urandom));
      // now and then cancel a matching term so the sum is zero
      for (int m = 0; m < na; m++) begin
        if (exps_a[m] == exps_b[k] && $urandom_range(3) == 0) coeffs_b[k] = -coeffs_a[m];
      end
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if ($urandom_range(19) == 0)
        queue_request(OP_UNUSED, 16'($urandom), 16'($urandom));
      if (ib >= nb || (ia < na && $urandom_range(1) == 0)) begin
        queue_request(OP_LOAD_A, coeffs_a[ia], exps_a[ia]);
        ia++;
      end else begin
        queue_request(OP_LOAD_B, coeffs_b[ib], exps_b[ib]);
        ib++;
      end
    end
    if (do_merge) queue_request(OP_MERGE, 16'($urandom), 16'($urandom));
  endtask

  initial begin : stimulus
    int unsigned seq_idx;
    int unsigned kind;
    int unsigned na;
    int unsigned nb;
    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.op       = OP_LOAD_A;
    in_bus.coeff_in = '0;
    in_bus.exp_in   = '0;
    out_bus.ready   = 1'b0;

    // merge with both lists empty
    queue_request(OP_MERGE, 16'hffff, 16'hffff);
    // extreme coefficients and exponents, sums at both ends of range and a zero sum
    queue_request(OP_LOAD_A, 16'h7fff, 16'hffff);
    queue_request(OP_LOAD_A, 16'h8000, 16'd100);
    queue_request(OP_LOAD_A, 16'h0001, 16'h0000);
    queue_request(OP_LOAD_B, 16'h7fff, 16'hffff);
    queue_request(OP_LOAD_B, 16'h8000, 16'd100);
    queue_request(OP_LOAD_B, 16'hffff, 16'h0000);
    queue_request(OP_MERGE, 16'h0000, 16'h0000);
    // only list A, then only list B
    queue_request(OP_LOAD_A, 16'd5, 16'd7);
    queue_request(OP_MERGE, 16'h5a5a, 16'ha5a5);
    queue_request(OP_LOAD_B, -16'sd5, 16'd3);
    queue_request(OP_LOAD_B, 16'd2, 16'd1);
    queue_request(OP_MERGE, 16'h0000, 16'h0000);
    // unused op code leaves lists alone
    queue_request(OP_UNUSED, 16'hffff, 16'hffff);
    queue_request(OP_MERGE, 16'h0000, 16'h0000);
    // unordered lists
    queue_request(OP_LOAD_A, 16'd1, 16'd5);
    queue_request(OP_LOAD_A, 16'd2, 16'd10);
    queue_request(OP_LOAD_B, 16'd3, 16'd7);
    queue_request(OP_MERGE, 16'h0000, 16'h0000);

    seq_idx = 0;
    while (counted_items < RAND_ITEMS) begin
      kind = $urandom_range(15);
      if (seq_idx == 0) begin
        // overfill list A
        na = 34;
        nb = $urandom_range(0, 4);
      end else if (seq_idx == 1) begin
        na = $urandom_range(0, 4);
        nb = 34;
      end else if (kind == 0) begin
        na = $urandom_range(28, 34);
        nb = $urandom_range(0, 34);
      end else begin
        na = $urandom_range(0, 6);
        nb = $urandom_range(0, 6);
      end
      queue_polynomials(na, nb, (kind != 1), (kind != 2 || seq_idx < 2));
      seq_idx++;
    end
    queue_request(OP_MERGE, 16'h0000, 16'h0000);
    total_count = req_queue.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (expected_terms.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_terms.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
